FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the list core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

FILE: rtl/core/plsort_pkg.sv
// Package with field widths, request and status codes and defaults of the list core.
package plsort_pkg;

	localparam int FUNC_W = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int STATUS_W = 2;
	localparam int CNT_W = 7;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_INSERT     = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_POP_FRONT  = 3'd4,
		FN_REMOVE     = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Operation broadcast to every cell of the row.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_PRM,
		OP_SRM
	} cell_op_t;

endpackage

FILE: rtl/core/plsort_if.sv
// Request and response channel interfaces of the list core.
interface plsort_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [plsort_pkg::FUNC_W-1:0]           func;
	logic [plsort_pkg::POS_W-1:0]            position;
	logic signed [plsort_pkg::VAL_W-1:0]     value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface plsort_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic [plsort_pkg::STATUS_W-1:0]         status;
	logic [plsort_pkg::CNT_W-1:0]            count;
	logic signed [plsort_pkg::VAL_W-1:0]     min_value;
	logic signed [plsort_pkg::VAL_W-1:0]     max_value;
	logic                                    is_empty;

	modport source (output valid, output status, output count, output min_value,
		output max_value, output is_empty, input ready);
	modport sink (input valid, input status, input count, input min_value,
		input max_value, input is_empty, output ready);
endinterface

FILE: rtl/core/plsort_cell.sv
// One cell of the list row: one entry in position order and one in sorted order.
module plsort_cell #(
	parameter int CAPACITY = plsort_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = plsort_pkg::DATA_WIDTH_DEF,
	parameter int IDX = 0
) (
	input  logic                                          clk,
	input  plsort_pkg::cell_op_t                          op,
	input  logic [((($clog2(CAPACITY + 1)) > plsort_pkg::POS_W) ?
		($clog2(CAPACITY + 1)) : plsort_pkg::POS_W)-1:0]   pos,
	input  logic signed [DATA_WIDTH-1:0]                  val,
	input  logic [$clog2(CAPACITY + 1)-1:0]               count,
	input  logic signed [DATA_WIDTH-1:0]                  pos_left,
	input  logic signed [DATA_WIDTH-1:0]                  pos_right,
	input  logic signed [DATA_WIDTH-1:0]                  sort_left,
	input  logic signed [DATA_WIDTH-1:0]                  sort_right,
	input  logic                                          lt_left,
	output logic                                          lt,
	output logic signed [DATA_WIDTH-1:0]                  pos_q,
	output logic signed [DATA_WIDTH-1:0]                  sort_q
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > plsort_pkg::POS_W) ? CW : plsort_pkg::POS_W;
	localparam logic [CMPW-1:0] IDX_X = CMPW'(IDX);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic below_pos;
	logic at_pos;
	logic take_new;

	assign below_pos = IDX_X < pos;
	assign at_pos = IDX_X == pos;
	assign lt = (IDX_C < count) && (sort_q < val);
	assign take_new = (IDX == 0) || lt_left;

	always_ff @(posedge clk) begin
		unique case (op)
			plsort_pkg::OP_INS: begin
				if (!below_pos) begin
					pos_q <= at_pos ? val : pos_left;
				end
				if (!lt) begin
					sort_q <= take_new ? val : sort_left;
				end
			end
			plsort_pkg::OP_PRM: begin
				if (!below_pos) begin
					pos_q <= pos_right;
				end
			end
			plsort_pkg::OP_SRM: begin
				if (!lt) begin
					sort_q <= sort_right;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/positional_list_with_sorted_order_core.sv
// Top level of the bounded list core that keeps position order and sorted order.
// The list lives in a row of CAPACITY cells; each request is decoded once and
// broadcast to all cells, which shift their entries toward or away from the
// neighbor in the same cycle. The result of a push, insert or failed request is
// loaded into the output register from the finish state that follows the
// request transfer, and that of a pop or remove only after a sorted-removal
// state, because the removed value is first read off the position row and then
// broadcast to the sorted row. The next request is taken in the cycle after the
// result is loaded, so the core takes no new request before it has finished the
// last one. A result that waits in the output register holds the finishing
// step, and with it the input.
`include "assert_macros.svh"

module positional_list_with_sorted_order_core #(
	parameter int CAPACITY = plsort_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = plsort_pkg::DATA_WIDTH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	plsort_req_if.sink     req,
	plsort_rsp_if.source   rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > plsort_pkg::POS_W) ? CW : plsort_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT_RM,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	plsort_pkg::status_t             status_q;
	logic signed [DATA_WIDTH-1:0]    rm_val_q;
	logic                            out_valid_q;
	logic [plsort_pkg::STATUS_W-1:0] out_status_q;
	logic [plsort_pkg::CNT_W-1:0]    out_count_q;
	logic signed [plsort_pkg::VAL_W-1:0] out_min_q;
	logic signed [plsort_pkg::VAL_W-1:0] out_max_q;
	logic                            out_empty_q;

	logic                            acc;
	logic                            out_load;
	logic [CMPW-1:0]                 count_x;
	logic [CMPW-1:0]                 req_pos_x;
	logic [CMPW-1:0]                 ins_pos;
	logic [CMPW-1:0]                 dec_pos;
	plsort_pkg::status_t             dec_status;
	plsort_pkg::cell_op_t            dec_op;
	plsort_pkg::cell_op_t            cell_op;
	logic signed [DATA_WIDTH-1:0]    req_val;
	logic signed [DATA_WIDTH-1:0]    bcast_val;
	logic signed [DATA_WIDTH-1:0]    rm_bus;
	logic signed [DATA_WIDTH-1:0]    max_bus;
	logic signed [plsort_pkg::VAL_W-1:0] min_ext;
	logic signed [plsort_pkg::VAL_W-1:0] max_ext;

	logic signed [DATA_WIDTH-1:0]    pos_d [CAPACITY];
	logic signed [DATA_WIDTH-1:0]    sort_d [CAPACITY];
	logic signed [DATA_WIDTH-1:0]    pos_left_d [CAPACITY];
	logic signed [DATA_WIDTH-1:0]    pos_right_d [CAPACITY];
	logic signed [DATA_WIDTH-1:0]    sort_left_d [CAPACITY];
	logic signed [DATA_WIDTH-1:0]    sort_right_d [CAPACITY];
	logic [CAPACITY-1:0]             lt_v;
	logic [CAPACITY-1:0]             lt_left_v;

	assign req.ready = (state_q == ST_IDLE);
	assign acc = req.valid && req.ready;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);
	assign count_x = CMPW'(count_q);
	assign req_pos_x = CMPW'(req.position);
	assign req_val = DATA_WIDTH'(req.value);

	always_comb begin
		dec_status = plsort_pkg::ST_OK;
		dec_op = plsort_pkg::OP_NONE;
		dec_pos = '0;
		ins_pos = req_pos_x;
		unique case (plsort_pkg::func_t'(req.func))
			plsort_pkg::FN_PUSH_FRONT, plsort_pkg::FN_PUSH_BACK, plsort_pkg::FN_INSERT: begin
				if (plsort_pkg::func_t'(req.func) == plsort_pkg::FN_PUSH_FRONT) begin
					ins_pos = '0;
				end else if (plsort_pkg::func_t'(req.func) == plsort_pkg::FN_PUSH_BACK) begin
					ins_pos = count_x;
				end
				if (ins_pos > count_x) begin
					dec_status = plsort_pkg::ST_BAD_POS;
				end else if (count_q >= CW'(CAPACITY)) begin
					dec_status = plsort_pkg::ST_FULL;
				end else begin
					dec_op = plsort_pkg::OP_INS;
					dec_pos = ins_pos;
				end
			end
			plsort_pkg::FN_POP_BACK, plsort_pkg::FN_POP_FRONT: begin
				if (count_q == '0) begin
					dec_status = plsort_pkg::ST_EMPTY;
				end else begin
					dec_op = plsort_pkg::OP_PRM;
					dec_pos = (plsort_pkg::func_t'(req.func) == plsort_pkg::FN_POP_BACK) ?
						count_x - CMPW'(1) : '0;
				end
			end
			plsort_pkg::FN_REMOVE: begin
				if (count_q == '0) begin
					dec_status = plsort_pkg::ST_EMPTY;
				end else if (req_pos_x >= count_x) begin
					dec_status = plsort_pkg::ST_BAD_POS;
				end else begin
					dec_op = plsort_pkg::OP_PRM;
					dec_pos = req_pos_x;
				end
			end
			default: begin
				dec_status = plsort_pkg::ST_BAD_POS;
			end
		endcase
	end

	always_comb begin
		cell_op = plsort_pkg::OP_NONE;
		if (state_q == ST_SORT_RM) begin
			cell_op = plsort_pkg::OP_SRM;
		end else if (acc) begin
			cell_op = dec_op;
		end
	end

	assign bcast_val = (state_q == ST_SORT_RM) ? rm_val_q : req_val;

	// Each cell's entry is ORed onto the removal bus or the maximum bus when selected.
	always_comb begin
		rm_bus = '0;
		max_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMPW'(i) == dec_pos) begin
				rm_bus = rm_bus | pos_d[i];
			end
			if (CW'(i) == count_q - CW'(1)) begin
				max_bus = max_bus | sort_d[i];
			end
		end
	end

	assign min_ext = plsort_pkg::VAL_W'(sort_d[0]);
	assign max_ext = plsort_pkg::VAL_W'(max_bus);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign pos_left_d[g] = pos_d[g];
			assign sort_left_d[g] = sort_d[g];
			assign lt_left_v[g] = 1'b0;
		end else begin : g_inner
			assign pos_left_d[g] = pos_d[g-1];
			assign sort_left_d[g] = sort_d[g-1];
			assign lt_left_v[g] = lt_v[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign pos_right_d[g] = pos_d[g];
			assign sort_right_d[g] = sort_d[g];
		end else begin : g_body
			assign pos_right_d[g] = pos_d[g+1];
			assign sort_right_d[g] = sort_d[g+1];
		end

		plsort_cell #(
			.CAPACITY(CAPACITY),
			.DATA_WIDTH(DATA_WIDTH),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.op(cell_op),
			.pos(dec_pos),
			.val(bcast_val),
			.count(count_q),
			.pos_left(pos_left_d[g]),
			.pos_right(pos_right_d[g]),
			.sort_left(sort_left_d[g]),
			.sort_right(sort_right_d[g]),
			.lt_left(lt_left_v[g]),
			.lt(lt_v[g]),
			.pos_q(pos_d[g]),
			.sort_q(sort_d[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			status_q <= plsort_pkg::ST_OK;
			rm_val_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= '0;
			out_count_q <= '0;
			out_min_q <= '0;
			out_max_q <= '0;
			out_empty_q <= 1'b1;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						status_q <= dec_status;
						rm_val_q <= rm_bus;
						if (dec_op == plsort_pkg::OP_INS) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= (dec_op == plsort_pkg::OP_PRM) ? ST_SORT_RM : ST_FINISH;
					end
				end
				ST_SORT_RM: begin
					count_q <= count_q - CW'(1);
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						out_status_q <= status_q;
						out_count_q <= plsort_pkg::CNT_W'(count_q);
						out_empty_q <= (count_q == '0);
						out_min_q <= (count_q == '0) ? '0 : min_ext;
						out_max_q <= (count_q == '0) ? '0 : max_ext;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.count = out_count_q;
	assign rsp.min_value = out_min_q;
	assign rsp.max_value = out_max_q;
	assign rsp.is_empty = out_empty_q;

	`ASSERT_CLK(a_count_bound, count_q <= CW'(CAPACITY), "Element count exceeds capacity.")
	`ASSERT_CLK(a_sort_rm_entry,
		state_q == ST_SORT_RM |->
		$past(state_q) == ST_IDLE && $past(dec_op) == plsort_pkg::OP_PRM,
		"Sorted removal without an accepted removal.")
	`ASSERT_CLK(a_insert_grows,
		acc && dec_op == plsort_pkg::OP_INS |=> count_q == $past(count_q) + CW'(1),
		"Insert did not grow the count.")
	`ASSERT_CLK(a_rsp_empty_flag, rsp.valid |-> rsp.is_empty == (rsp.count == '0), "Empty flag disagrees with count.")

endmodule

FILE: test/tb_positional_list_with_sorted_order_core.sv
// Testbench for the list core: directed and randomized requests checked against a queue-based predictor.
`timescale 1ns / 100ps

module tb_positional_list_with_sorted_order_core;

	localparam int CAP = plsort_pkg::CAPACITY_DEF;
	localparam int FW = plsort_pkg::FUNC_W;
	localparam int PW = plsort_pkg::POS_W;
	localparam int VW = plsort_pkg::VAL_W;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 400;
	localparam logic [FW-1:0] FN_UNKNOWN_LO = 3'd6;
	localparam logic [FW-1:0] FN_UNKNOWN_HI = 3'd7;
	localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic [FW-1:0] func;
		logic [PW-1:0] position;
		logic signed [VW-1:0] value;
	} request_t;

	typedef struct {
		logic [plsort_pkg::STATUS_W-1:0] status;
		logic [plsort_pkg::CNT_W-1:0] count;
		logic [VW-1:0] min_value;
		logic [VW-1:0] max_value;
		logic is_empty;
	} list_summary_t;

	typedef enum int {
		MOOD_FILL,
		MOOD_DRAIN,
		MOOD_MIXED,
		MOOD_NOISE,
		MOOD_PUSH_ONLY,
		MOOD_POP_ONLY
	} mood_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plsort_req_if req_ch ();
	plsort_rsp_if rsp_ch ();

	positional_list_with_sorted_order_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #1 clk = ~clk;

	request_t request_backlog[$];
	list_summary_t awaited_summaries[$];
	logic signed [VW-1:0] by_position[$];
	logic signed [VW-1:0] by_value[$];

	int planned_count = 0;
	int mismatches = 0;
	int summaries_seen = 0;
	bit req_fired = 1'b0;
	bit rsp_fired = 1'b0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;
	bit hold_done = 1'b0;
	int req_wait = 0;
	int rsp_wait = 0;
	int hold_left = 0;
	request_t next_req;
	request_t taken_req;
	list_summary_t want;

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int pick_gap(bit calm);
		return calm ? 0 : int'($urandom_range(0, 11));
	endfunction

	// Applies one request to the shadow list and returns the summary it should produce.
	function automatic list_summary_t apply_request(request_t r);
		list_summary_t s;
		int n;
		int at;
		int k;
		logic signed [VW-1:0] v;
		n = by_position.size();
		v = r.value;
		s.status = plsort_pkg::ST_OK;
		case (r.func)
			plsort_pkg::FN_PUSH_FRONT, plsort_pkg::FN_PUSH_BACK, plsort_pkg::FN_INSERT: begin
				if (r.func == plsort_pkg::FN_PUSH_FRONT)
					at = 0;
				else if (r.func == plsort_pkg::FN_PUSH_BACK)
					at = n;
				else
					at = int'(r.position);
				if (at > n) begin
					s.status = plsort_pkg::ST_BAD_POS;
				end else if (n >= CAP) begin
					s.status = plsort_pkg::ST_FULL;
				end else begin
					by_position.insert(at, v);
					k = 0;
					while (k < by_value.size() && by_value[k] < v)
						k++;
					by_value.insert(k, v);
				end
			end
			plsort_pkg::FN_POP_BACK, plsort_pkg::FN_POP_FRONT, plsort_pkg::FN_REMOVE: begin
				if (r.func == plsort_pkg::FN_POP_BACK)
					at = n - 1;
				else if (r.func == plsort_pkg::FN_POP_FRONT)
					at = 0;
				else
					at = int'(r.position);
				if (n == 0) begin
					s.status = plsort_pkg::ST_EMPTY;
				end else if (at >= n) begin
					s.status = plsort_pkg::ST_BAD_POS;
				end else begin
					v = by_position[at];
					by_position.delete(at);
					k = 0;
					while (k + 1 < by_value.size() && by_value[k] != v)
						k++;
					by_value.delete(k);
				end
			end
			default: begin
				s.status = plsort_pkg::ST_BAD_POS;
			end
		endcase
		s.count = plsort_pkg::CNT_W'(by_position.size());
		s.is_empty = (by_position.size() == 0);
		s.min_value = s.is_empty ? '0 : by_value[0];
		s.max_value = s.is_empty ? '0 : by_value[by_value.size() - 1];
		return s;
	endfunction

	task automatic queue_request(logic [FW-1:0] f, logic [PW-1:0] p,
			logic signed [VW-1:0] v);
		request_t r;
		r.func = f;
		r.position = p;
		r.value = v;
		request_backlog.insert(request_backlog.size(), r);
		case (f)
			plsort_pkg::FN_PUSH_FRONT, plsort_pkg::FN_PUSH_BACK: begin
				if (planned_count < CAP)
					planned_count++;
			end
			plsort_pkg::FN_INSERT: begin
				if (int'(p) <= planned_count && planned_count < CAP)
					planned_count++;
			end
			plsort_pkg::FN_POP_BACK, plsort_pkg::FN_POP_FRONT: begin
				if (planned_count > 0)
					planned_count--;
			end
			plsort_pkg::FN_REMOVE: begin
				if (planned_count > 0 && int'(p) < planned_count)
					planned_count--;
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic signed [VW-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			case ($urandom_range(0, 4))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end else if (roll <= 3) begin
			return $signed($urandom_range(0, 8)) - 4;
		end
		return $urandom;
	endfunction

	task automatic queue_random(mood_t mood);
		int roll;
		bit grow;
		logic [FW-1:0] f;
		logic [PW-1:0] p;
		roll = $urandom_range(0, 99);
		case (mood)
			MOOD_FILL: grow = (roll < 85);
			MOOD_DRAIN: grow = (roll < 15);
			MOOD_PUSH_ONLY: grow = 1'b1;
			MOOD_POP_ONLY: grow = 1'b0;
			default: grow = (roll < 50);
		endcase
		if (mood == MOOD_NOISE)
			f = FW'($urandom_range(0, 7));
		else if (mood == MOOD_MIXED && roll >= 95)
			f = (roll[0]) ? FN_UNKNOWN_LO : FN_UNKNOWN_HI;
		else if (grow)
			case ($urandom_range(0, 2))
				0: f = plsort_pkg::FN_PUSH_FRONT;
				1: f = plsort_pkg::FN_PUSH_BACK;
				default: f = plsort_pkg::FN_INSERT;
			endcase
		else
			case ($urandom_range(0, 2))
				0: f = plsort_pkg::FN_POP_BACK;
				1: f = plsort_pkg::FN_POP_FRONT;
				default: f = plsort_pkg::FN_REMOVE;
			endcase
		p = PW'($urandom_range(0, 127));
		if ($urandom_range(0, 9) != 0) begin
			if (f == plsort_pkg::FN_INSERT)
				p = PW'($urandom_range(0, planned_count));
			else if (f == plsort_pkg::FN_REMOVE && planned_count > 0)
				p = PW'($urandom_range(0, planned_count - 1));
		end
		queue_request(f, p, pick_value());
	endtask

	// Driver: request fields change only on the falling edge.
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_fired)) begin
			if (req_wait > 0) begin
				req_ch.valid <= 1'b0;
				req_wait--;
			end else if (request_backlog.size() > 0) begin
				next_req = request_backlog[0];
				request_backlog.delete(0);
				req_ch.valid <= 1'b1;
				req_ch.func <= next_req.func;
				req_ch.position <= next_req.position;
				req_ch.value <= next_req.value;
				if ($urandom_range(0, 29) == 0)
					req_calm = !req_calm;
				req_wait = pick_gap(req_calm);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// One long hold-off of the receiver, counted on its own.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && summaries_seen >= HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// Receiver side of the response channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_fired) begin
				if ($urandom_range(0, 29) == 0)
					rsp_calm = !rsp_calm;
				rsp_wait = pick_gap(rsp_calm);
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (rsp_wait > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_wait--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: checks each response transfer, then predicts any request transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			rsp_fired <= rsp_ch.valid && rsp_ch.ready;
			req_fired <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				summaries_seen++;
				if (awaited_summaries.size() == 0) begin
					report_mismatch("response transfer with no request outstanding");
				end else begin
					want = awaited_summaries[0];
					awaited_summaries.delete(0);
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status want %0d got %0d",
							want.status, rsp_ch.status));
					if (rsp_ch.count !== want.count)
						report_mismatch($sformatf("count want %0d got %0d",
							want.count, rsp_ch.count));
					if (rsp_ch.min_value !== want.min_value)
						report_mismatch($sformatf("min_value want %h got %h",
							want.min_value, rsp_ch.min_value));
					if (rsp_ch.max_value !== want.max_value)
						report_mismatch($sformatf("max_value want %h got %h",
							want.max_value, rsp_ch.max_value));
					if (rsp_ch.is_empty !== want.is_empty)
						report_mismatch($sformatf("is_empty want %0d got %0d",
							want.is_empty, rsp_ch.is_empty));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				taken_req.func = req_ch.func;
				taken_req.position = req_ch.position;
				taken_req.value = req_ch.value;
				awaited_summaries.insert(awaited_summaries.size(), apply_request(taken_req));
			end
		end
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int target;
		mood_t mood;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// Empty list: failing pops and removes, unknown functions, insert past the end.
		queue_request(plsort_pkg::FN_POP_BACK, 7'd0, 0);
		queue_request(plsort_pkg::FN_POP_FRONT, 7'd0, 0);
		queue_request(plsort_pkg::FN_REMOVE, 7'd0, 0);
		queue_request(plsort_pkg::FN_REMOVE, 7'd127, 0);
		queue_request(FN_UNKNOWN_LO, 7'd0, 7);
		queue_request(FN_UNKNOWN_HI, 7'd127, VAL_MIN);
		queue_request(plsort_pkg::FN_INSERT, 7'd1, 3);
		// Extremes, duplicates and positions at and past the count.
		queue_request(plsort_pkg::FN_PUSH_FRONT, 7'd127, VAL_MAX);
		queue_request(plsort_pkg::FN_PUSH_BACK, 7'd0, VAL_MIN);
		queue_request(plsort_pkg::FN_INSERT, 7'd1, -1);
		queue_request(plsort_pkg::FN_INSERT, 7'd3, 0);
		queue_request(plsort_pkg::FN_INSERT, 7'd5, 9);
		queue_request(plsort_pkg::FN_PUSH_BACK, 7'd64, -1);
		queue_request(plsort_pkg::FN_PUSH_FRONT, 7'd0, VAL_MAX);
		queue_request(plsort_pkg::FN_REMOVE, 7'd6, 0);
		queue_request(plsort_pkg::FN_REMOVE, 7'd127, 0);
		queue_request(plsort_pkg::FN_REMOVE, 7'd2, 0);
		queue_request(plsort_pkg::FN_INSERT, 7'd0, 1);
		queue_request(plsort_pkg::FN_POP_BACK, 7'd0, 0);
		queue_request(plsort_pkg::FN_POP_FRONT, 7'd0, 0);
		queue_request(plsort_pkg::FN_REMOVE, 7'd0, 0);
		queue_request(plsort_pkg::FN_INSERT, 7'd64, 5);

		target = request_backlog.size() + RANDOM_ITEMS;
		while (request_backlog.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: mood = MOOD_FILL;
				3, 4, 5: mood = MOOD_DRAIN;
				6, 7, 8: mood = MOOD_MIXED;
				default: mood = MOOD_NOISE;
			endcase
			if (mood == MOOD_FILL) begin
				while (planned_count < CAP)
					queue_random(MOOD_FILL);
				repeat ($urandom_range(2, 6)) queue_random(MOOD_PUSH_ONLY);
			end else if (mood == MOOD_DRAIN) begin
				while (planned_count > 0)
					queue_random(MOOD_DRAIN);
				repeat ($urandom_range(2, 6)) queue_random(MOOD_POP_ONLY);
			end else begin
				repeat ($urandom_range(10, 60)) queue_random(mood);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (awaited_summaries.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
